>>> rtl/maf_pkg.sv
// Shared constants and types of the moving-average filter.
// Used by every module of the block; depends on nothing.
`default_nettype none

package maf_pkg;

  // Field and register widths
  localparam int SAMPLE_W      = 16;
  localparam int DEPTH_CFG_W   = 5;
  localparam int CFG_ADDR_W    = 1;
  localparam int CFG_DATA_W    = 5;

  // Window defaults
  localparam int MAX_DEPTH_DEF = 16;
  localparam int DEPTH_RESET   = 16;

  // Register indexes of the configuration port
  localparam logic [CFG_ADDR_W-1:0] REG_FILTER_ENABLE = 1'b0;
  localparam logic [CFG_ADDR_W-1:0] REG_WINDOW_DEPTH  = 1'b1;

  // Status of the serial divider as seen by the controller
  typedef struct packed {
    logic busy;
    logic done;
  } div_status_t;

endpackage

`default_nettype wire

>>> rtl/maf_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Depends on maf_pkg for its default geometry.
`default_nettype none

module maf_ram import maf_pkg::*; #(
  parameter int WIDTH = SAMPLE_W,
  parameter int DEPTH = MAX_DEPTH_DEF
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // Write one entry, read one entry into the output register
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

>>> rtl/maf_divider.sv
// Bit-serial signed divider: one quotient bit per cycle, truncation toward zero.
// Depends on maf_pkg for the result width and the status struct.
`default_nettype none

module maf_divider import maf_pkg::*; #(
  parameter int TW = SAMPLE_W + $clog2(MAX_DEPTH_DEF) + 1,
  parameter int DW = $clog2(MAX_DEPTH_DEF + 1)
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       start_i,
  input  wire logic signed [TW-1:0]       dividend_i,
  input  wire logic        [DW-1:0]       divisor_i,
  output div_status_t                     status_o,
  output logic signed      [SAMPLE_W-1:0] quotient_o
);

  localparam int CNTW = $clog2(TW);

  logic [TW-1:0]   mag_q, mag_d;
  logic [DW-1:0]   rem_q, rem_d;
  logic [CNTW-1:0] cnt_q, cnt_d;
  logic            neg_q, neg_d;
  logic            busy_q, busy_d;
  logic            done_q, done_d;

  logic [DW:0]     trial;
  logic [DW:0]     diff;
  logic            fits;
  logic [TW-1:0]   q_full;

  // Trial subtract of the divisor from the shifted remainder
  assign trial = {rem_q, mag_q[TW-1]};
  assign diff  = trial - {1'b0, divisor_i};
  assign fits  = (trial >= {1'b0, divisor_i});

  always_comb begin
    mag_d  = mag_q;
    rem_d  = rem_q;
    cnt_d  = cnt_q;
    neg_d  = neg_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      neg_d  = dividend_i[TW-1];
      mag_d  = dividend_i[TW-1] ? (TW'(0) - dividend_i) : dividend_i;
      rem_d  = '0;
      cnt_d  = CNTW'(TW - 1);
      busy_d = 1'b1;
    end else if (busy_q) begin
      // Shift one dividend bit in, one quotient bit out
      rem_d = fits ? diff[DW-1:0] : trial[DW-1:0];
      mag_d = {mag_q[TW-2:0], fits};
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mag_q <= mag_d;
    rem_q <= rem_d;
    cnt_q <= cnt_d;
    neg_q <= neg_d;
  end

  // Restore the sign and keep the sample-wide part
  assign q_full          = neg_q ? (TW'(0) - mag_q) : mag_q;
  assign quotient_o      = q_full[SAMPLE_W-1:0];
  assign status_o.busy   = busy_q;
  assign status_o.done   = done_q;

endmodule

`default_nettype wire

>>> rtl/moving_average_filter_core.sv
// Moving-average filter: window controller, sample RAM and serial divider.
// Depends on maf_pkg, maf_ram and maf_divider.
//
// Usage:
//   Input channel (in_valid_i/in_ready_o) carries sample_i and clear_request_i.
//   Output channel (out_valid_o/out_ready_i) carries filtered_o, one per request.
//   Configuration channel (cfg_valid_i/cfg_ready_o, cfg_addr_i, cfg_data_i)
//   writes filter_enable (index 0) and window_depth (index 1); it is always
//   ready and must only be used while the block is idle. Writing window_depth
//   clears the window.
//   Sequence: a pass-through request (disabled or clear) goes from acceptance
//   to the done state and from there into the output register. An averaged
//   request passes the update, start, divide and done states; the first
//   sample after a clear fills the window one entry per cycle in the fill
//   state in place of the update state. The bit-serial divider yields one
//   quotient bit per cycle for a TW-bit dividend, TW = 16 + clog2(MAX_DEPTH) + 1.
//   One request is in work at a time: the next is accepted once the last has left done.
//   Reset: window empty, filtering disabled, depth 16 (saturated to MAX_DEPTH).
//   Stall: a finished result waits in the output register; the next request
//   is accepted meanwhile and holds in its final step until the register frees.
`default_nettype none

module moving_average_filter_core import maf_pkg::*; #(
  parameter int MAX_DEPTH = MAX_DEPTH_DEF
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        in_valid_i,
  output logic                             in_ready_o,
  input  wire logic signed [SAMPLE_W-1:0]  sample_i,
  input  wire logic                        clear_request_i,
  output logic                             out_valid_o,
  input  wire logic                        out_ready_i,
  output logic signed      [SAMPLE_W-1:0]  filtered_o,
  input  wire logic                        cfg_valid_i,
  output logic                             cfg_ready_o,
  input  wire logic        [CFG_ADDR_W-1:0] cfg_addr_i,
  input  wire logic        [CFG_DATA_W-1:0] cfg_data_i
);

  localparam int AW   = $clog2(MAX_DEPTH);
  localparam int DW   = $clog2(MAX_DEPTH + 1);
  localparam int TW   = SAMPLE_W + $clog2(MAX_DEPTH) + 1;
  localparam int CMPW = (DW > DEPTH_CFG_W) ? DW : DEPTH_CFG_W;
  localparam int RESET_DEPTH = (DEPTH_RESET > MAX_DEPTH) ? MAX_DEPTH : DEPTH_RESET;

  // Controller states
  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_UPDATE = 3'd1;
  localparam logic [2:0] S_FILL   = 3'd2;
  localparam logic [2:0] S_START  = 3'd3;
  localparam logic [2:0] S_DIV    = 3'd4;
  localparam logic [2:0] S_DONE   = 3'd5;

  logic [2:0]                 state_q, state_d;
  logic                       enable_q, enable_d;
  logic [DW-1:0]              depth_q, depth_d;
  logic [AW-1:0]              wpos_q, wpos_d;
  logic [AW-1:0]              fill_q, fill_d;
  logic                       awaiting_q, awaiting_d;
  logic signed [TW-1:0]       total_q, total_d;
  logic signed [SAMPLE_W-1:0] sample_q, sample_d;
  logic signed [SAMPLE_W-1:0] res_q, res_d;
  logic                       out_valid_q, out_valid_d;
  logic signed [SAMPLE_W-1:0] out_data_q, out_data_d;

  logic                       in_acc;
  logic                       cfg_acc;
  logic [AW-1:0]              depth_m1;
  logic signed [TW-1:0]       sample_ext;
  logic signed [TW-1:0]       old_ext;

  logic                       ram_we;
  logic [AW-1:0]              ram_waddr;
  logic [SAMPLE_W-1:0]        ram_rdata;
  logic                       div_start;
  div_status_t                div_status;
  logic signed [SAMPLE_W-1:0] div_quot;

  // Map a written depth onto 1..MAX_DEPTH
  function automatic logic [DW-1:0] clamp_depth(input logic [DEPTH_CFG_W-1:0] v);
    logic [CMPW-1:0] ext;
    logic [DW-1:0]   res;
    ext = CMPW'(v);
    if (ext == '0) begin
      res = DW'(1);
    end else if (ext > CMPW'(MAX_DEPTH)) begin
      res = DW'(MAX_DEPTH);
    end else begin
      res = DW'(ext);
    end
    return res;
  endfunction

  assign in_ready_o  = (state_q == S_IDLE);
  assign cfg_ready_o = 1'b1;
  assign in_acc      = in_valid_i && in_ready_o;
  assign cfg_acc     = cfg_valid_i && cfg_ready_o;
  assign depth_m1    = AW'(depth_q - 1'b1);
  assign sample_ext  = {{(TW - SAMPLE_W){sample_q[SAMPLE_W-1]}}, sample_q};
  assign old_ext     = {{(TW - SAMPLE_W){ram_rdata[SAMPLE_W-1]}}, ram_rdata};

  // Sample RAM: the oldest entry is always read at the write position
  assign ram_we    = (state_q == S_UPDATE) || (state_q == S_FILL);
  assign ram_waddr = (state_q == S_FILL) ? fill_q : wpos_q;

  maf_ram #(
    .WIDTH (SAMPLE_W),
    .DEPTH (MAX_DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (sample_q),
    .raddr_i (wpos_q),
    .rdata_o (ram_rdata)
  );

  assign div_start = (state_q == S_START);

  maf_divider #(
    .TW (TW),
    .DW (DW)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (total_q),
    .divisor_i  (depth_q),
    .status_o   (div_status),
    .quotient_o (div_quot)
  );

  // Sequence one request and keep the window bookkeeping
  always_comb begin
    state_d     = state_q;
    enable_d    = enable_q;
    depth_d     = depth_q;
    wpos_d      = wpos_q;
    fill_d      = fill_q;
    awaiting_d  = awaiting_q;
    total_d     = total_q;
    sample_d    = sample_q;
    res_d       = res_q;
    out_valid_d = out_valid_q;
    out_data_d  = out_data_q;

    // Drop the result once the receiver takes it
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          sample_d = sample_i;
          if (!enable_q || clear_request_i) begin
            res_d      = sample_i;
            wpos_d     = '0;
            awaiting_d = 1'b1;
            total_d    = '0;
            state_d    = S_DONE;
          end else if (awaiting_q) begin
            fill_d  = '0;
            total_d = '0;
            state_d = S_FILL;
          end else begin
            state_d = S_UPDATE;
          end
        end
      end
      S_UPDATE: begin
        total_d = total_q - old_ext + sample_ext;
        wpos_d  = (wpos_q == depth_m1) ? '0 : wpos_q + 1'b1;
        state_d = S_START;
      end
      S_FILL: begin
        total_d = total_q + sample_ext;
        if (fill_q == depth_m1) begin
          awaiting_d = 1'b0;
          wpos_d     = '0;
          state_d    = S_START;
        end else begin
          fill_d = fill_q + 1'b1;
        end
      end
      S_START: begin
        state_d = S_DIV;
      end
      S_DIV: begin
        if (div_status.done) begin
          res_d   = div_quot;
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          out_data_d  = res_q;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    // Apply register writes; a depth write clears the window
    if (cfg_acc) begin
      unique case (cfg_addr_i)
        REG_FILTER_ENABLE: begin
          enable_d = cfg_data_i[0];
        end
        REG_WINDOW_DEPTH: begin
          depth_d    = clamp_depth(cfg_data_i[DEPTH_CFG_W-1:0]);
          wpos_d     = '0;
          awaiting_d = 1'b1;
          total_d    = '0;
        end
        default: begin
          enable_d = enable_q;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      enable_q    <= 1'b0;
      depth_q     <= DW'(RESET_DEPTH);
      wpos_q      <= '0;
      awaiting_q  <= 1'b1;
      total_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      enable_q    <= enable_d;
      depth_q     <= depth_d;
      wpos_q      <= wpos_d;
      awaiting_q  <= awaiting_d;
      total_q     <= total_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    fill_q     <= fill_d;
    sample_q   <= sample_d;
    res_q      <= res_d;
    out_data_q <= out_data_d;
  end

  assign out_valid_o = out_valid_q;
  assign filtered_o  = out_data_q;

`ifndef SYNTHESIS
  // The write position stays inside the active window once it is filled
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !awaiting_q |-> (DW'(wpos_q) < depth_q))
    else $error("write position outside the active window");

  // The divider is only started when idle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_start |-> !div_status.busy)
    else $error("divider started while busy");

  // A finished division always lands in the wait-for-result state
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_status.done |-> (state_q == S_DIV))
    else $error("divider result with no request waiting");

  // A depth write always leaves the window awaiting its first sample
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cfg_acc && (cfg_addr_i == REG_WINDOW_DEPTH)) |=> awaiting_q)
    else $error("depth write did not clear the window");
`endif

endmodule

`default_nettype wire
